>>> rtl/rgba_palette_indexer_top_macros.svh
// assertion macros used by the checker file
`ifndef RGBA_PALETTE_INDEXER_TOP_MACROS_SVH
`define RGBA_PALETTE_INDEXER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RPI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgba palette indexer: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define RPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgba palette indexer: next-cycle check failed");

`endif

>>> rtl/rpi_pkg.sv
package rpi_pkg;

  // palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = IDX_W + 1;

  // channel widths
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 48;
  localparam int M_USER_W = 2;

  // color packing
  localparam logic [7:0]  OPAQUE_ALPHA = 8'hFF;
  localparam logic [7:0]  COLOR_ALPHA  = 8'h80;
  localparam logic [31:0] TRANSPARENT  = 32'h0000_0000;

  // index permutation codes on bits 4..3
  localparam logic [1:0] SEL_ONE = 2'b01;
  localparam logic [1:0] SEL_TWO = 2'b10;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } rpi_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic done;
    logic out_free;
  } rpi_status_t;

  // swap bit pairs 01 and 10 at bits 4..3
  function automatic logic [7:0] permute_index(input logic [7:0] idx);
    logic [7:0] res;
    res = idx;
    if (idx[4:3] == SEL_ONE) begin
      res[4:3] = SEL_TWO;
    end else if (idx[4:3] == SEL_TWO) begin
      res[4:3] = SEL_ONE;
    end
    return res;
  endfunction

endpackage

>>> rtl/rpi_ctrl.sv
module rpi_ctrl
  import rpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  rpi_status_t status,
  output rpi_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state;

  // commands decoded from state, input handshake and output status
  always_comb begin
    cmd        = '0;
    cmd.load   = s_tvalid && s_tready;
    cmd.search = (state == S_SEARCH);
    cmd.commit = (state == S_FINISH) && status.out_free;
  end

  // state and ready register, ready stays low while in reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= S_SEARCH;
            s_tready <= 1'b0;
          end else begin
            s_tready <= 1'b1;
          end
        end
        S_SEARCH: begin
          if (status.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (status.out_free) begin
            state    <= S_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          s_tready <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/rpi_datapath.sv
module rpi_datapath
  import rpi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rpi_cmd_t            cmd,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  input  logic                m_tready,
  output rpi_status_t         status,
  output logic                m_tvalid,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  logic [31:0]      mem [PALETTE_ENTRIES];
  logic [31:0]      color;
  logic [31:0]      color_in;
  logic [31:0]      rdata;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] idx;
  logic             rd_pend;
  logic             found;
  logic             hit_now;
  logic             issue;
  logic             full;

  // pack the incoming pixel, non-opaque becomes transparent
  always_comb begin
    if (s_tdata[31:24] == OPAQUE_ALPHA) begin
      color_in = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], COLOR_ALPHA};
    end else begin
      color_in = TRANSPARENT;
    end
  end

  // search control: slot 0 is the transparent color and is never read
  assign hit_now = rd_pend && (rdata == color);
  assign issue   = cmd.search && !found && !hit_now && (ptr != count);
  assign full    = (count == CNT_W'(PALETTE_ENTRIES));

  assign status.done     = found || (!rd_pend && (ptr == count));
  assign status.out_free = !m_tvalid || m_tready;

  // palette memory, one read and one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[ptr[IDX_W-1:0]];
    end
    if (cmd.commit && !found && !full) begin
      mem[count[IDX_W-1:0]] <= color;
    end
  end

  // pixel color and read pointer
  always_ff @(posedge clk) begin
    rd_ptr <= ptr[IDX_W-1:0];
    if (cmd.load) begin
      color <= color_in;
      ptr   <= CNT_W'(1);
    end else if (issue) begin
      ptr <= ptr + CNT_W'(1);
    end
  end

  // match tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      rd_pend <= issue && !cmd.load;
      if (cmd.load) begin
        found <= (color_in == TRANSPARENT);
      end else if (hit_now) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (hit_now) begin
      idx <= rd_ptr;
    end
  end

  // palette fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
    end else if (cmd.load && s_tuser[0]) begin
      count <= CNT_W'(1);
    end else if (cmd.commit && !found && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (found) begin
        m_tdata <= {32'h0, 8'h0, permute_index(8'(idx))};
        m_tuser <= 2'b00;
      end else if (full) begin
        m_tdata <= '0;
        m_tuser <= 2'b10;
      end else begin
        m_tdata <= {color, 8'(count[IDX_W-1:0]), permute_index(8'(count[IDX_W-1:0]))};
        m_tuser <= 2'b01;
      end
    end
  end

endmodule

>>> rtl/rgba_palette_indexer_top.sv
// RGBA palette indexer: takes one RGBA pixel per input word and returns one result word
// with its permuted palette index, plus the slot and color word when the pixel added a new
// color, or an overflow flag when the palette of 256 slots was full (index 0 then).
// A pixel whose alpha is not 0xFF maps to the transparent color in slot 0; first_pixel in
// s_tuser restarts the palette. One pixel is in flight at a time, and its lookup is a linear
// search through the palette memory over its single read port, one slot per cycle. The
// next pixel is accepted while a finished result waits in the output register.
module rgba_palette_indexer_top
  import rpi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // red, green, blue, alpha
  input  logic [S_USER_W-1:0] s_tuser,   // first_pixel
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // pixel_code, entry_slot, entry_color
  output logic [M_USER_W-1:0] m_tuser    // new_entry, overflow
);

  rpi_cmd_t    cmd;
  rpi_status_t status;

  rpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rpi_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/rgba_palette_indexer_checker.sv
`include "rgba_palette_indexer_top_macros.svh"

module rgba_palette_indexer_checker
  import rpi_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic [S_USER_W-1:0] s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [M_USER_W-1:0] m_tuser
);

  logic entry_ok;

  // new color word carries the COLOR_ALPHA byte and a nonzero slot
  assign entry_ok = (m_tdata[23:16] == COLOR_ALPHA) && (m_tdata[15:8] != 8'h00);

  // overflow drops the color and points at the transparent slot
  `RPI_ASSERT_NOW(a_ovf_clean, clk, rst, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tuser[0])

  // without a new color the entry fields stay zero
  `RPI_ASSERT_NOW(a_no_entry_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[47:8] == 40'h0)

  // a new color carries COLOR_ALPHA and never lands in the transparent slot
  `RPI_ASSERT_NOW(a_entry_opaque, clk, rst, m_tvalid && m_tuser[0], entry_ok)

  // a stalled result word holds
  `RPI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind rgba_palette_indexer_top rgba_palette_indexer_checker u_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rpi_pkg::*;

  // one pixel as it travels on the input stream
  typedef struct packed {
    logic       first;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // one lookup outcome as it travels on the output stream
  typedef struct packed {
    logic [7:0]  code;
    logic        fresh;
    logic [7:0]  slot;
    logic [31:0] color;
    logic        ovf;
  } lookup_t;

  localparam int TARGET_PIXELS = 1200;
  localparam int MAX_SHOWN     = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // red, green, blue, alpha
  logic [S_USER_W-1:0] s_tuser = '0;   // first_pixel
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // pixel_code, entry_slot, entry_color
  logic [M_USER_W-1:0] m_tuser;        // new_entry, overflow

  // pixels waiting to be sent, lookups waiting to come back
  pixel_t  pixel_q[$];
  lookup_t lookup_q[$];

  // private copy of the palette
  logic [31:0] palette_mem[PALETTE_ENTRIES];
  int          palette_used;

  pixel_t cur_pixel;
  bit     stim_ready = 1'b0;
  int     total_pixels = 0;
  int     sent_cnt = 0;
  int     accepted_cnt = 0;
  int     returned_cnt = 0;
  int     mismatch_cnt = 0;
  int     phase_one = 0;
  int     phase_two = 0;

  rgba_palette_indexer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // swap index bits 4..3 between 01 and 10
  function automatic logic [7:0] swap_code_bits(input logic [7:0] idx);
    logic [7:0] res;
    res = idx;
    if (idx[4:3] == 2'b01) begin
      res = idx + 8'd8;
    end else if (idx[4:3] == 2'b10) begin
      res = idx - 8'd8;
    end
    return res;
  endfunction

  // look the pixel up in the palette copy and update it
  function automatic lookup_t index_pixel(input pixel_t p);
    lookup_t     res;
    logic [31:0] word;
    int          hit;
    int          idx;
    int          k;
    res  = '0;
    word = TRANSPARENT;
    hit  = -1;
    if (p.first) begin
      palette_mem[0] = TRANSPARENT;
      palette_used   = 1;
    end
    if (p.alpha == OPAQUE_ALPHA) begin
      word = {p.red, p.green, p.blue, COLOR_ALPHA};
    end
    for (k = 0; k < palette_used; k++) begin
      if (hit < 0 && palette_mem[k] == word) begin
        hit = k;
      end
    end
    if (hit >= 0) begin
      idx = hit;
    end else if (palette_used >= PALETTE_ENTRIES) begin
      idx     = 0;
      res.ovf = 1'b1;
    end else begin
      idx              = palette_used;
      palette_mem[idx] = word;
      palette_used     = palette_used + 1;
      res.fresh        = 1'b1;
      res.slot         = idx[7:0];
      res.color        = word;
    end
    res.code = swap_code_bits(idx[7:0]);
    return res;
  endfunction

  task automatic add_pixel(input logic first, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a);
    pixel_t p;
    p.first = first;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    pixel_q.push_back(p);
  endtask

  // image drawn from a small random set of colors, restarting the palette when first is set
  task automatic add_image(input logic first);
    logic [23:0] colors[40];
    int          n;
    int          m;
    int          i;
    int          c;
    n = $urandom_range(60, 5);
    m = $urandom_range(40, 1);
    for (i = 0; i < m; i++) begin
      colors[i] = 24'($urandom);
    end
    for (i = 0; i < n; i++) begin
      c = $urandom_range(m - 1);
      if ($urandom_range(99) < 85) begin
        add_pixel(first && i == 0, colors[c][23:16], colors[c][15:8], colors[c][7:0],
                  OPAQUE_ALPHA);
      end else begin
        add_pixel(first && i == 0, colors[c][23:16], colors[c][15:8], colors[c][7:0],
                  8'($urandom_range(255)));
      end
    end
  endtask

  // fill every slot, then probe the full palette
  task automatic add_fill();
    logic [7:0] g;
    logic [7:0] b;
    int         k;
    int         i;
    int         sel;
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    add_pixel(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(254)));
    for (k = 0; k < PALETTE_ENTRIES - 1; k++) begin
      if (k > 0 && $urandom_range(7) == 0) begin
        add_pixel(1'b0, 8'($urandom_range(k - 1)), g, b, OPAQUE_ALPHA);
      end
      add_pixel(1'b0, 8'(k), g, b, OPAQUE_ALPHA);
    end
    for (i = 0; i < 24; i++) begin
      sel = $urandom_range(2);
      if (sel == 0) begin
        add_pixel(1'b0, 8'($urandom_range(255)), g ^ 8'h01, b, OPAQUE_ALPHA);
      end else if (sel == 1) begin
        add_pixel(1'b0, 8'($urandom_range(PALETTE_ENTRIES - 2)), g, b, OPAQUE_ALPHA);
      end else begin
        add_pixel(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(254)));
      end
    end
  endtask

  // stimulus list
  initial begin
    int fills;
    int kind;
    int i;
    int n;
    fills = 0;
    palette_mem[0] = TRANSPARENT;
    palette_used   = 1;

    // directed corners
    add_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFE);
    add_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF);
    add_pixel(1'b0, 8'h12, 8'h34, 8'h56, 8'h7F);
    add_pixel(1'b1, 8'hA5, 8'h5A, 8'hC3, 8'h00);
    add_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_pixel(1'b1, 8'h80, 8'h80, 8'h80, 8'hFF);
    add_pixel(1'b0, 8'h01, 8'h02, 8'h04, 8'hFF);
    add_pixel(1'b0, 8'h80, 8'h80, 8'h80, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h01);
    add_pixel(1'b1, 8'h00, 8'h00, 8'h00, 8'h80);

    // random sequences
    while (pixel_q.size() < TARGET_PIXELS) begin
      kind = $urandom_range(99);
      if ((fills == 0 && pixel_q.size() >= 300) || (fills == 1 && pixel_q.size() >= 800)) begin
        add_fill();
        fills++;
      end else if (kind < 75) begin
        add_image(1'b1);
      end else if (kind < 85) begin
        add_image(1'b0);
      end else begin
        n = $urandom_range(5, 1);
        for (i = 0; i < n; i++) begin
          add_pixel(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      end
    end

    total_pixels = pixel_q.size();
    phase_one    = total_pixels / 3;
    phase_two    = 2 * total_pixels / 3;
    stim_ready   = 1'b1;
  end

  // reset
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: record accepted word, then offer the next one
  always @(posedge clk) begin
    int tx_idle;
    bit held;
    if (!rst && stim_ready) begin
      if (s_tvalid && s_tready) begin
        lookup_q.push_back(index_pixel(cur_pixel));
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        tx_idle = (sent_cnt < phase_one) ? 18 : (sent_cnt < phase_two) ? 54 : 0;
        // hold off at the first phase change until the pipeline drains
        held = (sent_cnt == phase_one) && (lookup_q.size() != 0);
        if (pixel_q.size() > 0 && !held && $urandom_range(99) >= tx_idle) begin
          cur_pixel = pixel_q.pop_front();
          sent_cnt++;
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_pixel.alpha, cur_pixel.blue, cur_pixel.green, cur_pixel.red};
          s_tuser  <= cur_pixel.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and compare against the oldest lookup
  always @(posedge clk) begin
    int      rx_idle;
    lookup_t got;
    lookup_t want;
    if (!rst && stim_ready) begin
      rx_idle = (returned_cnt < phase_one) ? 54 : (returned_cnt < phase_two) ? 18 : 0;
      m_tready <= ($urandom_range(99) >= rx_idle);
      if (m_tvalid && m_tready) begin
        got.code  = m_tdata[7:0];
        got.slot  = m_tdata[15:8];
        got.color = m_tdata[47:16];
        got.fresh = m_tuser[0];
        got.ovf   = m_tuser[1];
        returned_cnt++;
        if (lookup_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN) begin
            $display("unexpected word: code %h slot %h color %h new %b ovf %b",
                     got.code, got.slot, got.color, got.fresh, got.ovf);
          end
        end else begin
          want = lookup_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN) begin
              $display("word %0d mismatch: exp code %h slot %h color %h new %b ovf %b",
                       returned_cnt, want.code, want.slot, want.color, want.fresh, want.ovf);
              $display("              got code %h slot %h color %h new %b ovf %b",
                       got.code, got.slot, got.color, got.fresh, got.ovf);
            end
          end
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_ready);
    while (accepted_cnt < total_pixels || lookup_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);
    if (mismatch_cnt == 0 && lookup_q.size() == 0) begin
      $display("rgba_palette_indexer_top verification clean");
    end else begin
      $display("rgba_palette_indexer_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("rgba_palette_indexer_top verification failed");
    $finish;
  end

endmodule

>>> rgba_palette_indexer_top.f
+incdir+rtl
rtl/rpi_pkg.sv
rtl/rpi_ctrl.sv
rtl/rpi_datapath.sv
rtl/rgba_palette_indexer_top.sv
rtl/rgba_palette_indexer_checker.sv
test/tb_top.sv
